FILE: rtl/core/vomp_pkg.sv
`timescale 1ns / 1ps

package vomp_pkg;

	localparam int NUM_VIRTUAL  = 16;
	localparam int NUM_PHYSICAL = 16;

	// index widths; owner field holds a virtual index, 0 = unassigned
	localparam int VIRT_IW = (NUM_VIRTUAL > 1) ? $clog2(NUM_VIRTUAL) : 1;
	localparam int PIN_IW  = (NUM_PHYSICAL > 1) ? $clog2(NUM_PHYSICAL) : 1;
	localparam int CNT_W   = (VIRT_IW > PIN_IW) ? VIRT_IW : PIN_IW;

	localparam logic [7:0] LONG_PULSE_RESET = 8'd15;

	// command codes
	localparam logic [2:0] CMD_ASSIGN   = 3'd0;
	localparam logic [2:0] CMD_ACTIVATE = 3'd1;
	localparam logic [2:0] CMD_ACTION   = 3'd2;
	localparam logic [2:0] CMD_TICK     = 3'd3;
	localparam logic [2:0] CMD_SYNC     = 3'd4;

	// function codes
	localparam logic [2:0] FN_NONE   = 3'd0;
	localparam logic [2:0] FN_TOGGLE = 3'd1;
	localparam logic [2:0] FN_HIGH   = 3'd2;
	localparam logic [2:0] FN_LOW    = 3'd3;
	localparam logic [2:0] FN_SHORT  = 3'd4;
	localparam logic [2:0] FN_LONG   = 3'd5;

	typedef struct packed {
		logic [2:0] command;
		logic [3:0] virtual_index;
		logic [3:0] physical_index;
		logic [2:0] function_code;
		logic       initial_level;
		logic [7:0] elapsed_ticks;
	} in_t;

	typedef struct packed {
		logic [15:0] pin_levels;
		logic        assign_ok;
		logic        last_result;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_VWALK,
		ST_PWALK,
		ST_EMIT_MID,
		ST_EMIT_END
	} state_t;

	// decode status from datapath to sequencer
	typedef struct packed {
		logic [2:0] cmd;
		logic [2:0] func;
		logic       v_ok;
		logic       long_idle;
	} dec_t;

	// sequencer controls to datapath
	typedef struct packed {
		logic             in_ready;
		logic             accept;
		logic             decode;
		logic             vwalk;
		logic             pwalk;
		logic             emit;
		logic             emit_last;
		logic [CNT_W-1:0] cnt;
	} ctl_t;

endpackage

FILE: rtl/core/vomp_ctrl.sv
`timescale 1ns / 1ps

module vomp_ctrl import vomp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  dec_t dec,
	input  logic slot_free,
	output ctl_t ctl
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             short_q;
	logic             pass2_q;
	logic             v_last;
	logic             p_last;
	logic             is_act;

	assign v_last = (cnt_q == CNT_W'(NUM_VIRTUAL - 1));
	assign p_last = (cnt_q == CNT_W'(NUM_PHYSICAL - 1));
	assign is_act = (dec.cmd == CMD_ACTIVATE) || (dec.cmd == CMD_ACTION);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				state_d = ST_EMIT_END;
				if (dec.cmd == CMD_TICK) begin
					state_d = ST_VWALK;
				end else if (is_act && dec.v_ok) begin
					if (dec.func == FN_TOGGLE || dec.func == FN_HIGH ||
					    dec.func == FN_LOW || dec.func == FN_SHORT) begin
						state_d = ST_PWALK;
					end else if (dec.func == FN_LONG && dec.long_idle) begin
						state_d = ST_PWALK;
					end
				end
			end
			ST_VWALK: begin
				if (v_last) state_d = ST_PWALK;
			end
			ST_PWALK: begin
				if (p_last) state_d = (short_q && !pass2_q) ? ST_EMIT_MID : ST_EMIT_END;
			end
			ST_EMIT_MID: begin
				if (slot_free) state_d = ST_PWALK;
			end
			ST_EMIT_END: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl           = '0;
		ctl.in_ready  = (state_q == ST_IDLE);
		ctl.accept    = (state_q == ST_IDLE) && in_valid;
		ctl.decode    = (state_q == ST_DECODE);
		ctl.vwalk     = (state_q == ST_VWALK);
		ctl.pwalk     = (state_q == ST_PWALK);
		ctl.emit      = ((state_q == ST_EMIT_MID) || (state_q == ST_EMIT_END)) && slot_free;
		ctl.emit_last = (state_q == ST_EMIT_END);
		ctl.cnt       = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			short_q <= 1'b0;
			pass2_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// index restarts at every walk boundary
			if ((state_q == ST_VWALK && !v_last) || (state_q == ST_PWALK && !p_last)) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (state_q == ST_DECODE) short_q <= is_act && (dec.func == FN_SHORT);
			if (state_q == ST_IDLE) begin
				pass2_q <= 1'b0;
			end else if (state_q == ST_EMIT_MID && slot_free) begin
				pass2_q <= 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/virtual_output_mapper_pulse_core.sv
`timescale 1ns / 1ps

// Virtual output mapper with pulse support.
// Input channel in_valid/in_ready/in_data carries one command transaction;
// output channel out_valid/out_ready/out_data returns its results.
// cfg_wr_en/cfg_wr_data write the long pulse length; write only when idle.
// One command in flight at a time: in_ready is high only in the idle state.
// Steps from input transaction to its last result:
//   assign, sync, unknown codes, inert functions, running long pulse: decode, emit
//   toggle / set high / set low / idle long pulse:  decode, pin walk, emit
//   short pulse: decode, pin walk, first emit, pin walk, last emit
//   tick:        decode, counter walk, pin walk, emit
// The walks are done by the shared walk unit, which visits one pulse counter
// or one physical pin per cycle.
// A short pulse gives two results, toggled then restored, the first with
// last_result low.
// Results sit in a single output register; a stalled receiver holds the
// sequencer in its emit state until the slot drains.
// Reset (arst_n low) unassigns every pin, clears functions, pulse counters
// and pin levels, and loads a long pulse length of 15. No clearing pass.
module virtual_output_mapper_pulse_core import vomp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_t        in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_t       out_data,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data
);

	typedef enum logic [1:0] {PM_TOGGLE, PM_HIGH, PM_LOW} pin_mode_t;

	// stored state
	logic [VIRT_IW-1:0]      pin_owner_q   [NUM_PHYSICAL];
	logic [2:0]              group_func_q  [NUM_VIRTUAL];
	logic [7:0]              pulse_count_q [NUM_VIRTUAL];
	logic [NUM_PHYSICAL-1:0] shadow_q;
	logic [NUM_PHYSICAL-1:0] driven_q;
	logic [7:0]              long_pulse_q;

	// current command
	in_t                     item_q;
	logic [2:0]              func_q;
	logic [NUM_VIRTUAL-1:0]  mask_q;     // groups the pin walk acts on
	logic                    ok_q;

	logic                    out_valid_q;
	out_t                    out_q;

	ctl_t                    ctl;
	dec_t                    dec;
	logic                    slot_free;

	logic [VIRT_IW-1:0]      item_vidx;
	logic [PIN_IW-1:0]       item_pidx;
	logic [VIRT_IW-1:0]      walk_vidx;
	logic [PIN_IW-1:0]       walk_pidx;
	logic [PIN_IW-1:0]       own_ridx;
	logic [VIRT_IW-1:0]      cnt_ridx;
	logic [VIRT_IW-1:0]      owner_rd;
	logic [7:0]              count_rd;
	logic                    v_ok;
	logic                    p_ok;
	logic                    assign_hit;
	logic                    pin_hit;
	logic                    new_bit;
	pin_mode_t               mode;
	logic [15:0]             levels;

	vomp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.dec      (dec),
		.slot_free(slot_free),
		.ctl      (ctl)
	);

	assign in_ready  = ctl.in_ready;
	assign slot_free = !out_valid_q || out_ready;

	assign item_vidx = VIRT_IW'(item_q.virtual_index);
	assign item_pidx = PIN_IW'(item_q.physical_index);
	assign walk_vidx = ctl.cnt[VIRT_IW-1:0];
	assign walk_pidx = ctl.cnt[PIN_IW-1:0];
	assign v_ok      = (32'(item_q.virtual_index) < NUM_VIRTUAL);
	assign p_ok      = (32'(item_q.physical_index) < NUM_PHYSICAL);

	// one read port each on the owner and counter tables
	assign own_ridx  = ctl.decode ? item_pidx : walk_pidx;
	assign cnt_ridx  = ctl.vwalk ? walk_vidx : item_vidx;
	assign owner_rd  = pin_owner_q[own_ridx];
	assign count_rd  = pulse_count_q[cnt_ridx];

	always_comb begin
		dec.cmd       = item_q.command;
		dec.func      = (item_q.command == CMD_ACTIVATE) ? group_func_q[item_vidx]
		                                                 : item_q.function_code;
		dec.v_ok      = v_ok;
		dec.long_idle = (count_rd == 8'd0);
	end

	assign assign_hit = (item_q.command == CMD_ASSIGN) && v_ok && (item_q.virtual_index != 4'd0)
	                    && p_ok && (owner_rd == '0);

	// pin walk unit: owner lookup against the group mask, then level update
	always_comb begin
		if (item_q.command == CMD_TICK) begin
			mode = PM_TOGGLE;
		end else begin
			priority case (func_q)
				FN_HIGH: mode = PM_HIGH;
				FN_LOW:  mode = PM_LOW;
				default: mode = PM_TOGGLE;
			endcase
		end
	end

	assign pin_hit = mask_q[owner_rd];

	always_comb begin
		unique case (mode)
			PM_HIGH: new_bit = 1'b1;
			PM_LOW:  new_bit = 1'b0;
			default: new_bit = ~shadow_q[walk_pidx];
		endcase
	end

	// item and per-command registers; the null output owns no pins, so its
	// mask bit stays low and unassigned pins are never touched
	always_ff @(posedge clk) begin
		if (ctl.accept) item_q <= in_data;
		if (ctl.decode) begin
			func_q <= dec.func;
			ok_q   <= assign_hit;
			mask_q <= ((item_q.command != CMD_TICK) && (item_vidx != '0))
			          ? (NUM_VIRTUAL'(1) << item_vidx) : '0;
		end else if (ctl.vwalk) begin
			if (count_rd != 8'd0 && item_q.elapsed_ticks >= count_rd)
				mask_q[walk_vidx] <= (walk_vidx != '0);
		end
	end

	// mapping state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_owner_q   <= '{default: '0};
			group_func_q  <= '{default: FN_NONE};
			pulse_count_q <= '{default: '0};
			shadow_q      <= '0;
			driven_q      <= '0;
			long_pulse_q  <= LONG_PULSE_RESET;
		end else begin
			if (cfg_wr_en) long_pulse_q <= cfg_wr_data;
			if (ctl.decode) begin
				if (assign_hit) begin
					pin_owner_q[item_pidx]   <= item_vidx;
					shadow_q[item_pidx]      <= item_q.initial_level;
					group_func_q[item_vidx]  <= item_q.function_code;
				end
				if (item_q.command == CMD_SYNC) driven_q <= shadow_q;
				// long pulse arms its counter only when none is running
				if ((item_q.command == CMD_ACTIVATE || item_q.command == CMD_ACTION) && v_ok
				    && dec.func == FN_LONG && dec.long_idle) begin
					pulse_count_q[item_vidx] <= long_pulse_q;
				end
			end
			if (ctl.vwalk && count_rd != 8'd0) begin
				if (item_q.elapsed_ticks >= count_rd) begin
					pulse_count_q[walk_vidx] <= 8'd0;
				end else begin
					pulse_count_q[walk_vidx] <= count_rd - item_q.elapsed_ticks;
				end
			end
			if (ctl.pwalk && pin_hit) begin
				shadow_q[walk_pidx] <= new_bit;
				driven_q[walk_pidx] <= new_bit;
			end
		end
	end

	// pins above 15 stay internal; missing pins read low
	for (genvar i = 0; i < 16; i++) begin : g_levels
		if (i < NUM_PHYSICAL) begin : g_pin
			assign levels[i] = driven_q[i];
		end else begin : g_none
			assign levels[i] = 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_q.pin_levels  <= levels;
			out_q.assign_ok   <= ctl.emit_last && ok_q;
			out_q.last_result <= ctl.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept |=> !in_ready)
		else $error("input taken while a command is in progress");

	a_ok_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.assign_ok |-> out_data.last_result)
		else $error("assign status on a non-final result");

	a_null_group: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pwalk |-> !mask_q[0])
		else $error("walk acting on unassigned pins");

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (!out_valid || out_ready))
		else $error("result overwrote one not yet taken");

endmodule
